FILE: sv/mie_pkg.sv
// Shared definitions for the MIPS32 subset executor: opcodes, function codes,
// memory sizing and the controller/datapath interface structs.
// Used by every module of the block but mie_muldiv; depends on nothing.
`default_nettype none

package mie_pkg;

  // Data memory size in words (power of two) and its index width
  localparam int unsigned DMEM_WORDS = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);

  // Program counter after reset
  localparam logic [31:0] PC_RESET = 32'h0040_0000;

  // v0 value that makes a syscall halt the core
  localparam logic [31:0] SYSCALL_EXIT = 32'h0000_000A;
  localparam logic [4:0]  REG_V0       = 5'd2;
  localparam logic [4:0]  REG_RA       = 5'd31;

  // Item commands
  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // REGIMM branch selectors
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  // Controller to datapath commands
  typedef struct packed {
    logic boot;      // load pc from start_pc
    logic latch;     // capture the input word
    logic rd_regs;   // read the register file
    logic exec;      // decode, execute, issue memory read
    logic md_start;  // launch the multiply/divide unit
    logic commit;    // write back state and load the output word
  } mie_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_md;     // current instruction needs the multiply/divide unit
    logic md_done;   // multiply/divide result written to HI/LO
  } mie_sts_t;

endpackage

`default_nettype wire

FILE: sv/mie_muldiv.sv
// Iterative multiply/divide unit: 32 shift-add or restore-subtract steps on
// operand magnitudes, then a sign fix-up step. Depends on nothing.
`default_nettype none

module mie_muldiv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        is_div,
  input  wire logic        sgn,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic             done,
  output logic [31:0]      res_hi,
  output logic [31:0]      res_lo
);

  logic        busy_r, fin_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] acc_r;
  logic [31:0] mb_r;
  logic        div_r, negq_r, negr_r;
  logic [31:0] hi_r, lo_r;

  logic [31:0] ma, mb;
  logic [32:0] msum, dtry;
  logic [63:0] prod;
  logic [31:0] quo, rem;

  // Operand magnitudes
  assign ma = (sgn && op_a[31]) ? (32'd0 - op_a) : op_a;
  assign mb = (sgn && op_b[31]) ? (32'd0 - op_b) : op_b;

  // One step of each algorithm
  assign msum = {1'b0, acc_r[63:32]} + {1'b0, (acc_r[0] ? mb_r : 32'd0)};
  assign dtry = acc_r[63:31] - {1'b0, mb_r};

  // Sign fix-up
  assign prod = negq_r ? (64'd0 - acc_r) : acc_r;
  assign quo  = negq_r ? (32'd0 - acc_r[31:0]) : acc_r[31:0];
  assign rem  = negr_r ? (32'd0 - acc_r[63:32]) : acc_r[63:32];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // Datapath of the unit
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= {32'd0, ma};
      mb_r   <= mb;
      div_r  <= is_div;
      negq_r <= sgn && (op_a[31] ^ op_b[31]);
      negr_r <= sgn && op_a[31];
    end else if (busy_r) begin
      if (!div_r) begin
        acc_r <= {msum, acc_r[31:1]};
      end else if (!dtry[32]) begin
        acc_r <= {dtry[31:0], acc_r[30:0], 1'b1};
      end else begin
        acc_r <= {acc_r[62:0], 1'b0};
      end
    end
    if (fin_r) begin
      hi_r <= div_r ? rem : prod[63:32];
      lo_r <= div_r ? quo : prod[31:0];
    end
  end

  assign done   = done_r;
  assign res_hi = hi_r;
  assign res_lo = lo_r;

endmodule

`default_nettype wire

FILE: sv/mie_dpath.sv
// Datapath: register file, HI/LO, pc, data memory, decode/execute logic,
// multiply/divide unit and the output word register. Depends on mie_pkg,
// mie_muldiv.
`default_nettype none

module mie_dpath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mie_pkg::mie_cmd_t     cmd,
  output mie_pkg::mie_sts_t          sts,
  input  wire logic                  cfg_we,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  in_cmd,
  input  wire logic [31:0]           in_instr,
  input  wire logic [9:0]            in_load_index,
  input  wire logic [31:0]           in_load_word,
  output logic [31:0]                out_pc,
  output logic                       out_halted,
  output logic                       out_reg_written,
  output logic [4:0]                 out_reg_index,
  output logic [31:0]                out_reg_value,
  output logic                       out_store_done,
  output logic [9:0]                 out_store_index,
  output logic [3:0]                 out_store_mask,
  output logic [31:0]                out_store_value,
  output logic [31:0]                out_hi_value,
  output logic [31:0]                out_lo_value,
  output logic                       out_bad_instr
);

  localparam int unsigned AW = mie_pkg::DMEM_AW;

  // Architectural state
  logic [31:0] start_pc_r, pc_r, hi_r, lo_r;
  logic        halt_r;
  logic [31:0] gpr_mem [32];
  logic [31:0] gpr_vld_r;
  logic [31:0] dmem [mie_pkg::DMEM_WORDS];
  logic [31:0] dmem_q_r;

  // Latched item
  logic        cmd_r;
  logic [31:0] instr_r, lword_r;
  logic [9:0]  lidx_r;
  logic [31:0] a_r, b_r;

  // Execute results
  logic        wr_r, ld_r, st_r, bad_r, halt_set_r, hi_wr_r, lo_wr_r;
  logic [4:0]  widx_r;
  logic [31:0] wval_r, nxt_r, sval_r;
  logic [3:0]  smask_r;
  logic [AW-1:0] sidx_r;
  logic [1:0]  lane_r;

  // Output word
  logic [31:0] o_pc_r, o_wval_r, o_sval_r, o_hi_r, o_lo_r;
  logic        o_halt_r, o_wr_r, o_st_r, o_bad_r;
  logic [4:0]  o_widx_r;
  logic [9:0]  o_sidx_r;
  logic [3:0]  o_smask_r;

  // Instruction fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa, rb_addr;
  logic [31:0] simm, zimm, pc4, btgt, jtgt, addr;
  logic        live;

  assign op   = instr_r[31:26];
  assign fn   = instr_r[5:0];
  assign rs   = instr_r[25:21];
  assign rt   = instr_r[20:16];
  assign rd   = instr_r[15:11];
  assign sa   = instr_r[10:6];
  assign simm = {{16{instr_r[15]}}, instr_r[15:0]};
  assign zimm = {16'd0, instr_r[15:0]};
  assign pc4  = pc_r + 32'd4;
  assign btgt = pc4 + {simm[29:0], 2'b00};
  assign jtgt = {pc_r[31:28], instr_r[25:0], 2'b00};
  assign addr = a_r + simm;
  assign live = (cmd_r == mie_pkg::CMD_EXEC) && !halt_r;

  // Syscall reads v0 through the second port
  assign rb_addr = (op == mie_pkg::OP_SPECIAL && fn == mie_pkg::FN_SYSCALL) ?
                   mie_pkg::REG_V0 : rt;

  // Decode and execute
  logic        d_wr, d_ld, d_st, d_bad, d_halt, d_hiw, d_low, d_md, d_div, d_sgn;
  logic [4:0]  d_widx;
  logic [31:0] d_wval, d_nxt, d_sval;
  logic [3:0]  d_smask;
  logic        take;

  always_comb begin
    d_wr = 1'b0; d_ld = 1'b0; d_st = 1'b0; d_bad = 1'b0; d_halt = 1'b0;
    d_hiw = 1'b0; d_low = 1'b0; d_md = 1'b0; d_div = 1'b0; d_sgn = 1'b0;
    d_widx = rd; d_wval = '0; d_nxt = pc4; d_sval = '0; d_smask = '0;
    take = 1'b0;
    unique case (op) inside
      mie_pkg::OP_SPECIAL: begin
        unique case (fn) inside
          mie_pkg::FN_ADD, mie_pkg::FN_ADDU: begin d_wr = 1'b1; d_wval = a_r + b_r; end
          mie_pkg::FN_SUB, mie_pkg::FN_SUBU: begin d_wr = 1'b1; d_wval = a_r - b_r; end
          mie_pkg::FN_AND: begin d_wr = 1'b1; d_wval = a_r & b_r; end
          mie_pkg::FN_OR:  begin d_wr = 1'b1; d_wval = a_r | b_r; end
          mie_pkg::FN_XOR: begin d_wr = 1'b1; d_wval = a_r ^ b_r; end
          mie_pkg::FN_NOR: begin d_wr = 1'b1; d_wval = ~(a_r | b_r); end
          mie_pkg::FN_SLT: begin
            d_wr = 1'b1; d_wval = {31'd0, ($signed(a_r) < $signed(b_r))};
          end
          mie_pkg::FN_SLTU: begin d_wr = 1'b1; d_wval = {31'd0, (a_r < b_r)}; end
          mie_pkg::FN_SLL:  begin d_wr = 1'b1; d_wval = b_r << sa; end
          mie_pkg::FN_SRL:  begin d_wr = 1'b1; d_wval = b_r >> sa; end
          mie_pkg::FN_SRA:  begin d_wr = 1'b1; d_wval = 32'($signed(b_r) >>> sa); end
          mie_pkg::FN_SLLV: begin d_wr = 1'b1; d_wval = b_r << a_r[4:0]; end
          mie_pkg::FN_SRLV: begin d_wr = 1'b1; d_wval = b_r >> a_r[4:0]; end
          mie_pkg::FN_SRAV: begin
            d_wr = 1'b1; d_wval = 32'($signed(b_r) >>> a_r[4:0]);
          end
          mie_pkg::FN_MULT:  begin d_md = 1'b1; d_sgn = 1'b1; end
          mie_pkg::FN_MULTU: d_md = 1'b1;
          mie_pkg::FN_DIV:   begin d_md = (b_r != 32'd0); d_div = 1'b1; d_sgn = 1'b1; end
          mie_pkg::FN_DIVU:  begin d_md = (b_r != 32'd0); d_div = 1'b1; end
          mie_pkg::FN_MFHI:  begin d_wr = 1'b1; d_wval = hi_r; end
          mie_pkg::FN_MFLO:  begin d_wr = 1'b1; d_wval = lo_r; end
          mie_pkg::FN_MTHI:  d_hiw = 1'b1;
          mie_pkg::FN_MTLO:  d_low = 1'b1;
          mie_pkg::FN_SYSCALL: d_halt = (b_r == mie_pkg::SYSCALL_EXIT);
          mie_pkg::FN_JR:    d_nxt = a_r;
          mie_pkg::FN_JALR:  begin d_nxt = a_r; d_wr = 1'b1; d_wval = pc4; end
          default: d_bad = 1'b1;
        endcase
      end
      mie_pkg::OP_REGIMM: begin
        unique case (rt) inside
          mie_pkg::RI_BLTZ, mie_pkg::RI_BGEZ, mie_pkg::RI_BLTZAL, mie_pkg::RI_BGEZAL: begin
            take = rt[0] ? !a_r[31] : a_r[31];
            if (take) d_nxt = btgt;
            d_wr   = take && rt[4];
            d_widx = mie_pkg::REG_RA;
            d_wval = pc4;
          end
          default: d_bad = 1'b1;
        endcase
      end
      mie_pkg::OP_J:   d_nxt = jtgt;
      mie_pkg::OP_JAL: begin
        d_nxt = jtgt; d_wr = 1'b1; d_widx = mie_pkg::REG_RA; d_wval = pc4;
      end
      mie_pkg::OP_BEQ:  if (a_r == b_r) d_nxt = btgt;
      mie_pkg::OP_BNE:  if (a_r != b_r) d_nxt = btgt;
      mie_pkg::OP_BLEZ: if (a_r == 32'd0 || a_r[31]) d_nxt = btgt;
      mie_pkg::OP_BGTZ: if (a_r != 32'd0 && !a_r[31]) d_nxt = btgt;
      mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: begin
        d_wr = 1'b1; d_widx = rt; d_wval = a_r + simm;
      end
      mie_pkg::OP_SLTI: begin
        d_wr = 1'b1; d_widx = rt; d_wval = {31'd0, ($signed(a_r) < $signed(simm))};
      end
      mie_pkg::OP_SLTIU: begin
        d_wr = 1'b1; d_widx = rt; d_wval = {31'd0, (a_r < simm)};
      end
      mie_pkg::OP_ANDI: begin d_wr = 1'b1; d_widx = rt; d_wval = a_r & zimm; end
      mie_pkg::OP_ORI:  begin d_wr = 1'b1; d_widx = rt; d_wval = a_r | zimm; end
      mie_pkg::OP_XORI: begin d_wr = 1'b1; d_widx = rt; d_wval = a_r ^ zimm; end
      mie_pkg::OP_LUI:  begin d_wr = 1'b1; d_widx = rt; d_wval = {instr_r[15:0], 16'd0}; end
      mie_pkg::OP_LB, mie_pkg::OP_LBU, mie_pkg::OP_LH, mie_pkg::OP_LHU, mie_pkg::OP_LW: begin
        d_wr = 1'b1; d_ld = 1'b1; d_widx = rt;
      end
      mie_pkg::OP_SB: begin
        d_st = 1'b1; d_smask = 4'b0001 << addr[1:0];
        d_sval = {24'd0, b_r[7:0]} << {addr[1:0], 3'b000};
      end
      mie_pkg::OP_SH: begin
        d_st = 1'b1; d_smask = addr[1] ? 4'b1100 : 4'b0011;
        d_sval = addr[1] ? {b_r[15:0], 16'd0} : {16'd0, b_r[15:0]};
      end
      mie_pkg::OP_SW: begin d_st = 1'b1; d_smask = 4'b1111; d_sval = b_r; end
      default: d_bad = 1'b1;
    endcase
  end

  assign sts.is_md = live && d_md;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) start_pc_r <= mie_pkg::PC_RESET;
    else if (cfg_we) start_pc_r <= cfg_data;
  end

  // Item capture and register file read
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r   <= in_cmd;
      instr_r <= in_instr;
      lidx_r  <= in_load_index;
      lword_r <= in_load_word;
    end
    if (cmd.rd_regs) begin
      a_r <= gpr_vld_r[rs] ? gpr_mem[rs] : 32'd0;
      b_r <= gpr_vld_r[rb_addr] ? gpr_mem[rb_addr] : 32'd0;
    end
  end

  // Execute results, all effects gated off for preload and halted steps
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      wr_r       <= live && d_wr && (d_widx != 5'd0);
      widx_r     <= (live && d_wr) ? d_widx : 5'd0;
      wval_r     <= d_wval;
      ld_r       <= d_ld;
      st_r       <= live && d_st;
      sidx_r     <= (live && d_st) ? addr[AW+1:2] : '0;
      smask_r    <= (live && d_st) ? d_smask : 4'd0;
      sval_r     <= (live && d_st) ? d_sval : 32'd0;
      bad_r      <= live && d_bad;
      halt_set_r <= live && d_halt;
      hi_wr_r    <= live && d_hiw;
      lo_wr_r    <= live && d_low;
      nxt_r      <= live ? d_nxt : pc_r;
      lane_r     <= addr[1:0];
    end
  end

  // Load data alignment
  logic [7:0]  ld_byte;
  logic [15:0] ld_half;
  logic [31:0] ld_val, wval_fin;

  always_comb begin
    case (lane_r)
      2'd0:    ld_byte = dmem_q_r[7:0];
      2'd1:    ld_byte = dmem_q_r[15:8];
      2'd2:    ld_byte = dmem_q_r[23:16];
      default: ld_byte = dmem_q_r[31:24];
    endcase
    ld_half = lane_r[1] ? dmem_q_r[31:16] : dmem_q_r[15:0];
    unique case (op) inside
      mie_pkg::OP_LB:  ld_val = {{24{ld_byte[7]}}, ld_byte};
      mie_pkg::OP_LBU: ld_val = {24'd0, ld_byte};
      mie_pkg::OP_LH:  ld_val = {{16{ld_half[15]}}, ld_half};
      mie_pkg::OP_LHU: ld_val = {16'd0, ld_half};
      default:         ld_val = dmem_q_r;
    endcase
    wval_fin = !wr_r ? 32'd0 : (ld_r ? ld_val : wval_r);
  end

  // Data memory: byte-enable write at commit, registered read at execute
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic [3:0]    dm_be;

  assign dm_we    = cmd.commit && ((cmd_r == mie_pkg::CMD_PRELOAD) || st_r);
  assign dm_waddr = (cmd_r == mie_pkg::CMD_PRELOAD) ? AW'(lidx_r) : sidx_r;
  assign dm_wdata = (cmd_r == mie_pkg::CMD_PRELOAD) ? lword_r : sval_r;
  assign dm_be    = (cmd_r == mie_pkg::CMD_PRELOAD) ? 4'b1111 : smask_r;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      for (int k = 0; k < 4; k++) begin
        if (dm_be[k]) dmem[dm_waddr][8*k +: 8] <= dm_wdata[8*k +: 8];
      end
    end
    if (cmd.exec) dmem_q_r <= dmem[addr[AW+1:2]];
  end

  // Register file write; entries read as zero until written
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_r) gpr_mem[widx_r] <= wval_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) gpr_vld_r <= '0;
    else if (cmd.commit && wr_r) gpr_vld_r[widx_r] <= 1'b1;
  end

  // Multiply/divide unit
  logic        md_done;
  logic [31:0] md_hi, md_lo;

  mie_muldiv u_md (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.md_start),
    .is_div (d_div),
    .sgn    (d_sgn),
    .op_a   (a_r),
    .op_b   (b_r),
    .done   (md_done),
    .res_hi (md_hi),
    .res_lo (md_lo)
  );

  assign sts.md_done = md_done;

  // pc, HI/LO and halt
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= mie_pkg::PC_RESET;
      hi_r   <= '0;
      lo_r   <= '0;
      halt_r <= 1'b0;
    end else begin
      if (cmd.boot) pc_r <= start_pc_r;
      if (md_done) begin
        hi_r <= md_hi;
        lo_r <= md_lo;
      end
      if (cmd.commit) begin
        pc_r <= nxt_r;
        if (hi_wr_r) hi_r <= a_r;
        if (lo_wr_r) lo_r <= a_r;
        if (halt_set_r) halt_r <= 1'b1;
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_pc_r    <= nxt_r;
      o_halt_r  <= halt_r || halt_set_r;
      o_wr_r    <= wr_r;
      o_widx_r  <= widx_r;
      o_wval_r  <= wval_fin;
      o_st_r    <= st_r;
      o_sidx_r  <= 10'(sidx_r);
      o_smask_r <= smask_r;
      o_sval_r  <= sval_r;
      o_hi_r    <= hi_wr_r ? a_r : hi_r;
      o_lo_r    <= lo_wr_r ? a_r : lo_r;
      o_bad_r   <= bad_r;
    end
  end

  assign out_pc          = o_pc_r;
  assign out_halted      = o_halt_r;
  assign out_reg_written = o_wr_r;
  assign out_reg_index   = o_widx_r;
  assign out_reg_value   = o_wval_r;
  assign out_store_done  = o_st_r;
  assign out_store_index = o_sidx_r;
  assign out_store_mask  = o_smask_r;
  assign out_store_value = o_sval_r;
  assign out_hi_value    = o_hi_r;
  assign out_lo_value    = o_lo_r;
  assign out_bad_instr   = o_bad_r;

endmodule

`default_nettype wire

FILE: sv/mie_ctrl.sv
// Controller: sequences boot, read, execute, multiply/divide wait and
// commit, and owns the input stall and output valid. Depends on mie_pkg.
`default_nettype none

module mie_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire mie_pkg::mie_sts_t   sts,
  output mie_pkg::mie_cmd_t        cmd
);

  localparam logic [2:0] S_BOOT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_MD   = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       accept, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !ovld_r || !out_stall;
  assign out_valid = ovld_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_BOOT: begin
        cmd.boot  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.latch = accept;
        if (accept) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd_regs = 1'b1;
        state_nxt   = S_EX;
      end
      S_EX: begin
        cmd.exec     = 1'b1;
        cmd.md_start = sts.is_md;
        state_nxt    = sts.is_md ? S_MD : S_WB;
      end
      S_MD: begin
        if (sts.md_done) state_nxt = S_WB;
      end
      S_WB: begin
        cmd.commit = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    ovld_nxt = ovld_r;
    if (ovld_r && !out_stall) ovld_nxt = 1'b0;
    if (cmd.commit) ovld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mips32_instruction_executor.sv
// Top level of the MIPS32 subset executor: controller plus datapath.
// Depends on mie_pkg, mie_ctrl, mie_dpath, mie_muldiv.
//
// Each input word either executes one instruction fetched at out_pc or preloads
// one data memory word. One word is in the core at a time. An ordinary
// instruction or preload passes through register read, execute with data memory
// read and commit, and the next word is taken in the cycle that its result word
// appears. mult, multu, div and divu also run through the iterative
// multiply/divide unit, one bit per cycle; a divide by zero skips the unit.
// The result register frees the input side: a new word is taken while the
// previous result waits. After reset the core loads the pc from start_pc in a
// boot state. Data memory contents are undefined until preloaded or stored.
// cfg_ready is always high.
`default_nettype none

module mips32_instruction_executor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_instr,
  input  wire logic [9:0]  in_load_index,
  input  wire logic [31:0] in_load_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pc,
  output logic             out_halted,
  output logic             out_reg_written,
  output logic [4:0]       out_reg_index,
  output logic [31:0]      out_reg_value,
  output logic             out_store_done,
  output logic [9:0]       out_store_index,
  output logic [3:0]       out_store_mask,
  output logic [31:0]      out_store_value,
  output logic [31:0]      out_hi_value,
  output logic [31:0]      out_lo_value,
  output logic             out_bad_instr
);

  mie_pkg::mie_cmd_t cmd;
  mie_pkg::mie_sts_t sts;

  assign cfg_ready = 1'b1;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mie_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_cmd          (in_cmd),
    .in_instr        (in_instr),
    .in_load_index   (in_load_index),
    .in_load_word    (in_load_word),
    .out_pc          (out_pc),
    .out_halted      (out_halted),
    .out_reg_written (out_reg_written),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value),
    .out_store_done  (out_store_done),
    .out_store_index (out_store_index),
    .out_store_mask  (out_store_mask),
    .out_store_value (out_store_value),
    .out_hi_value    (out_hi_value),
    .out_lo_value    (out_lo_value),
    .out_bad_instr   (out_bad_instr)
  );

`ifndef SYNTHESIS
  // One word at a time: the core is busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while core busy");

  // A result never appears in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result word too early");

  // Register zero is never reported as written
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reg_written) |-> (out_reg_index != 5'd0))
    else $error("write to register zero reported");

  // A store always has at least one byte enable
  a_store_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_store_done) |-> (out_store_mask != 4'd0))
    else $error("store without byte enables");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_mips32_instruction_executor.sv
// Testbench for mips32_instruction_executor: directed table, then random words,
// every result word checked against a behavioral predictor of the core or, for typed rows, a fixed result.
// Depends on mie_pkg and the RTL of the executor only.
`timescale 1ns / 100ps

module tb_mips32_instruction_executor;

  typedef struct {
    logic        cmd;
    logic [31:0] instr;
    logic [9:0]  load_index;
    logic [31:0] load_word;
  } word_in_t;

  typedef struct {
    logic [31:0] pc;
    logic        halted;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_done;
    logic [9:0]  store_index;
    logic [3:0]  store_mask;
    logic [31:0] store_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        bad_instr;
  } word_out_t;

  typedef struct {
    word_in_t  w;
    bit        typed;
    word_out_t res;
  } row_t;

  localparam int LONG_HOLD = 300;
  localparam int SETTLE    = 60;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, in_cmd;
  logic [31:0] in_instr, in_load_word;
  logic [9:0] in_load_index;
  logic out_valid, out_stall;
  logic [31:0] out_pc, out_reg_value, out_store_value, out_hi_value, out_lo_value;
  logic out_halted, out_reg_written, out_store_done, out_bad_instr;
  logic [4:0] out_reg_index;
  logic [9:0] out_store_index;
  logic [3:0] out_store_mask;

  mips32_instruction_executor dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_instr(in_instr),
    .in_load_index(in_load_index), .in_load_word(in_load_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_pc(out_pc),
    .out_halted(out_halted), .out_reg_written(out_reg_written),
    .out_reg_index(out_reg_index), .out_reg_value(out_reg_value),
    .out_store_done(out_store_done), .out_store_index(out_store_index),
    .out_store_mask(out_store_mask), .out_store_value(out_store_value),
    .out_hi_value(out_hi_value), .out_lo_value(out_lo_value),
    .out_bad_instr(out_bad_instr)
  );

  always #5 clk = ~clk;

  // Shadow core state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, pc_q, start_pc_q;
  logic        halt_q;
  logic [31:0] dmem [mie_pkg::DMEM_WORDS];
  logic [3:0]  dmem_ok [mie_pkg::DMEM_WORDS];

  word_out_t pending_q [$];
  bit        failed = 0;
  int        stall_pct = 0;
  bit        hold_req = 0;
  bit        hold_taken = 0;
  int        hold_cnt = 0;
  int        burst_left = 0;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Bytes of the data memory that a load at this point would read
  function automatic logic [3:0] load_lanes(word_in_t w, output logic [9:0] idx);
    logic [5:0]  op;
    logic [31:0] addr;
    op   = w.instr[31:26];
    addr = gpr[w.instr[25:21]] + sx16(w.instr[15:0]);
    idx  = addr[11:2];
    if (w.cmd != mie_pkg::CMD_EXEC || halt_q) return 4'h0;
    case (op)
      mie_pkg::OP_LB, mie_pkg::OP_LBU: return 4'h1 << addr[1:0];
      mie_pkg::OP_LH, mie_pkg::OP_LHU: return 4'h3 << (2 * addr[1]);
      mie_pkg::OP_LW:                  return 4'hF;
      default:                         return 4'h0;
    endcase
  endfunction

  // Executes one word on the shadow state and returns its result word
  function automatic word_out_t predict_word(word_in_t w);
    word_out_t   r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [31:0] a, b, simm, zimm, pc4, nxt, addr, v, ua, ub, q, m, btgt;
    logic [63:0] p;
    logic [1:0]  lane;
    logic        neg;
    r = '{default: 0};
    op = w.instr[31:26]; fn = w.instr[5:0];
    rs = w.instr[25:21]; rt = w.instr[20:16]; rd = w.instr[15:11]; sa = w.instr[10:6];
    if (w.cmd == mie_pkg::CMD_PRELOAD) begin
      dmem[w.load_index] = w.load_word;
      dmem_ok[w.load_index] = 4'hF;
    end else if (!halt_q) begin
      a = gpr[rs]; b = gpr[rt];
      simm = sx16(w.instr[15:0]); zimm = {16'h0, w.instr[15:0]};
      pc4 = pc_q + 32'd4; nxt = pc4;
      btgt = pc4 + (simm << 2);
      addr = a + simm; lane = addr[1:0];
      case (op)
        mie_pkg::OP_SPECIAL: begin
          case (fn)
            mie_pkg::FN_ADD, mie_pkg::FN_ADDU: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = a + b;
            end
            mie_pkg::FN_SUB, mie_pkg::FN_SUBU: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = a - b;
            end
            mie_pkg::FN_AND: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = a & b;
            end
            mie_pkg::FN_OR: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = a | b;
            end
            mie_pkg::FN_XOR: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = a ^ b;
            end
            mie_pkg::FN_NOR: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = ~(a | b);
            end
            mie_pkg::FN_SLT: begin
              r.reg_written = 1; r.reg_index = rd;
              r.reg_value = {31'h0, $signed(a) < $signed(b)};
            end
            mie_pkg::FN_SLTU: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = {31'h0, a < b};
            end
            mie_pkg::FN_SLL: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = b << sa;
            end
            mie_pkg::FN_SRL: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = b >> sa;
            end
            mie_pkg::FN_SRA: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = $signed(b) >>> sa;
            end
            mie_pkg::FN_SLLV: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = b << a[4:0];
            end
            mie_pkg::FN_SRLV: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = b >> a[4:0];
            end
            mie_pkg::FN_SRAV: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = $signed(b) >>> a[4:0];
            end
            mie_pkg::FN_MULT: begin
              p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
              hi_q = p[63:32]; lo_q = p[31:0];
            end
            mie_pkg::FN_MULTU: begin
              p = {32'h0, a} * {32'h0, b};
              hi_q = p[63:32]; lo_q = p[31:0];
            end
            mie_pkg::FN_DIV: if (b != 0) begin
              // magnitudes, then signs; min / -1 wraps to min with zero remainder
              ua = a[31] ? -a : a;
              ub = b[31] ? -b : b;
              q = ua / ub; m = ua % ub;
              if (a[31] ^ b[31]) q = -q;
              if (a[31]) m = -m;
              lo_q = q; hi_q = m;
            end
            mie_pkg::FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
            mie_pkg::FN_MFHI: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = hi_q;
            end
            mie_pkg::FN_MFLO: begin
              r.reg_written = 1; r.reg_index = rd; r.reg_value = lo_q;
            end
            mie_pkg::FN_MTHI: hi_q = a;
            mie_pkg::FN_MTLO: lo_q = a;
            mie_pkg::FN_SYSCALL:
              if (gpr[mie_pkg::REG_V0] == mie_pkg::SYSCALL_EXIT) halt_q = 1;
            mie_pkg::FN_JR: nxt = a;
            mie_pkg::FN_JALR: begin
              nxt = a; r.reg_written = 1; r.reg_index = rd; r.reg_value = pc4;
            end
            default: r.bad_instr = 1;
          endcase
        end
        mie_pkg::OP_REGIMM: begin
          if (rt == mie_pkg::RI_BLTZ || rt == mie_pkg::RI_BGEZ ||
              rt == mie_pkg::RI_BLTZAL || rt == mie_pkg::RI_BGEZAL) begin
            neg = a[31];
            if (rt[0] ? !neg : neg) begin
              nxt = btgt;
              if (rt[4]) begin
                r.reg_written = 1; r.reg_index = mie_pkg::REG_RA; r.reg_value = pc4;
              end
            end
          end else r.bad_instr = 1;
        end
        mie_pkg::OP_J:   nxt = {pc_q[31:28], w.instr[25:0], 2'b00};
        mie_pkg::OP_JAL: begin
          nxt = {pc_q[31:28], w.instr[25:0], 2'b00};
          r.reg_written = 1; r.reg_index = mie_pkg::REG_RA; r.reg_value = pc4;
        end
        mie_pkg::OP_BEQ:  if (a == b) nxt = btgt;
        mie_pkg::OP_BNE:  if (a != b) nxt = btgt;
        mie_pkg::OP_BLEZ: if (a == 0 || a[31]) nxt = btgt;
        mie_pkg::OP_BGTZ: if (a != 0 && !a[31]) nxt = btgt;
        mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: begin
          r.reg_written = 1; r.reg_index = rt; r.reg_value = a + simm;
        end
        mie_pkg::OP_SLTI: begin
          r.reg_written = 1; r.reg_index = rt;
          r.reg_value = {31'h0, $signed(a) < $signed(simm)};
        end
        mie_pkg::OP_SLTIU: begin
          r.reg_written = 1; r.reg_index = rt; r.reg_value = {31'h0, a < simm};
        end
        mie_pkg::OP_ANDI: begin
          r.reg_written = 1; r.reg_index = rt; r.reg_value = a & zimm;
        end
        mie_pkg::OP_ORI: begin
          r.reg_written = 1; r.reg_index = rt; r.reg_value = a | zimm;
        end
        mie_pkg::OP_XORI: begin
          r.reg_written = 1; r.reg_index = rt; r.reg_value = a ^ zimm;
        end
        mie_pkg::OP_LUI: begin
          r.reg_written = 1; r.reg_index = rt; r.reg_value = {w.instr[15:0], 16'h0};
        end
        mie_pkg::OP_LB, mie_pkg::OP_LBU: begin
          v = (dmem[addr[11:2]] >> (8 * lane)) & 32'hFF;
          if (op == mie_pkg::OP_LB && v[7]) v = v | 32'hFFFFFF00;
          r.reg_written = 1; r.reg_index = rt; r.reg_value = v;
        end
        mie_pkg::OP_LH, mie_pkg::OP_LHU: begin
          v = (dmem[addr[11:2]] >> (16 * addr[1])) & 32'hFFFF;
          if (op == mie_pkg::OP_LH && v[15]) v = v | 32'hFFFF0000;
          r.reg_written = 1; r.reg_index = rt; r.reg_value = v;
        end
        mie_pkg::OP_LW: begin
          r.reg_written = 1; r.reg_index = rt; r.reg_value = dmem[addr[11:2]];
        end
        mie_pkg::OP_SB: begin
          r.store_done = 1; r.store_index = addr[11:2];
          r.store_mask = 4'h1 << lane; r.store_value = (b & 32'hFF) << (8 * lane);
        end
        mie_pkg::OP_SH: begin
          r.store_done = 1; r.store_index = addr[11:2];
          r.store_mask = 4'h3 << (2 * addr[1]);
          r.store_value = (b & 32'hFFFF) << (16 * addr[1]);
        end
        mie_pkg::OP_SW: begin
          r.store_done = 1; r.store_index = addr[11:2]; r.store_mask = 4'hF;
          r.store_value = b;
        end
        default: r.bad_instr = 1;
      endcase
      if (r.store_done) begin
        for (int k = 0; k < 4; k++)
          if (r.store_mask[k]) dmem[r.store_index][8*k +: 8] = r.store_value[8*k +: 8];
        dmem_ok[r.store_index] = dmem_ok[r.store_index] | r.store_mask;
      end
      // register zero never changes
      if (r.reg_written && r.reg_index != 0) gpr[r.reg_index] = r.reg_value;
      else begin r.reg_written = 0; r.reg_index = 0; r.reg_value = 0; end
      pc_q = nxt;
    end
    r.pc = pc_q; r.halted = halt_q; r.hi_value = hi_q; r.lo_value = lo_q;
    return r;
  endfunction

  // Offer one word and hold it until the core takes it; bursts and gaps
  task automatic offer_word(word_in_t w);
    in_valid <= 1'b1;
    in_cmd <= w.cmd; in_instr <= w.instr;
    in_load_index <= w.load_index; in_load_word <= w.load_word;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Send one word; a load of bytes never written gets its word preloaded first
  task automatic send_word(word_in_t w, bit typed = 0, word_out_t res = '{default: 0});
    word_in_t   fill;
    logic [9:0] idx;
    logic [3:0] need;
    word_out_t  e;
    need = load_lanes(w, idx);
    if ((dmem_ok[idx] & need) != need) begin
      fill = '{mie_pkg::CMD_PRELOAD, $urandom, idx, $urandom};
      pending_q.push_back(predict_word(fill));
      offer_word(fill);
    end
    e = predict_word(w);
    pending_q.push_back(typed ? res : e);
    offer_word(w);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] v);
    cfg_valid <= 1'b1; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_pc_q = v;
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One random instruction, mostly well formed with random operands
  function automatic logic [31:0] rand_instr();
    logic [5:0] ops [18] = '{mie_pkg::OP_J, mie_pkg::OP_JAL, mie_pkg::OP_BEQ,
      mie_pkg::OP_BNE, mie_pkg::OP_BLEZ, mie_pkg::OP_BGTZ, mie_pkg::OP_ADDI,
      mie_pkg::OP_ADDIU, mie_pkg::OP_SLTI, mie_pkg::OP_SLTIU, mie_pkg::OP_ANDI,
      mie_pkg::OP_ORI, mie_pkg::OP_XORI, mie_pkg::OP_LUI, mie_pkg::OP_ADDIU,
      mie_pkg::OP_ORI, mie_pkg::OP_LUI, mie_pkg::OP_ADDI};
    logic [5:0] alu [20] = '{mie_pkg::FN_ADD, mie_pkg::FN_ADDU, mie_pkg::FN_SUB,
      mie_pkg::FN_SUBU, mie_pkg::FN_AND, mie_pkg::FN_OR, mie_pkg::FN_XOR,
      mie_pkg::FN_NOR, mie_pkg::FN_SLT, mie_pkg::FN_SLTU, mie_pkg::FN_SLL,
      mie_pkg::FN_SRL, mie_pkg::FN_SRA, mie_pkg::FN_SLLV, mie_pkg::FN_SRLV,
      mie_pkg::FN_SRAV, mie_pkg::FN_MFHI, mie_pkg::FN_MFLO, mie_pkg::FN_MTHI,
      mie_pkg::FN_MTLO};
    logic [5:0] mem [8] = '{mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW,
      mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_SB, mie_pkg::OP_SH, mie_pkg::OP_SW};
    logic [5:0] md [4] = '{mie_pkg::FN_MULT, mie_pkg::FN_MULTU, mie_pkg::FN_DIV,
      mie_pkg::FN_DIVU};
    logic [4:0] ri [4] = '{mie_pkg::RI_BLTZ, mie_pkg::RI_BGEZ, mie_pkg::RI_BLTZAL,
      mie_pkg::RI_BGEZAL};
    logic [4:0] base;
    logic [31:0] ins;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5:
        ins = {mie_pkg::OP_SPECIAL, pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
               alu[$urandom_range(19)]};
      6: ins = {mie_pkg::OP_SPECIAL, pick_reg(), pick_reg(), pick_reg(), 5'd0,
                ($urandom_range(1) ? mie_pkg::FN_JR : mie_pkg::FN_JALR)};
      7: ins = {mie_pkg::OP_REGIMM, pick_reg(), ri[$urandom_range(3)], pick_imm()};
      8, 9: ins = {mie_pkg::OP_SPECIAL, pick_reg(), pick_reg(), 10'd0,
                   md[$urandom_range(3)]};
      10, 11, 12, 13: begin
        base = $urandom_range(1) ? 5'd0 : pick_reg();
        ins = {mem[$urandom_range(7)], base, pick_reg(), pick_imm()};
      end
      14: ins = {mie_pkg::OP_SPECIAL, 20'($urandom), mie_pkg::FN_SYSCALL};
      15: ins = $urandom;
      default: ins = {ops[$urandom_range(17)], pick_reg(), pick_reg(), pick_imm()};
    endcase
    // keep the core running: no exit call until the final phase
    if (ins[31:26] == mie_pkg::OP_SPECIAL && ins[5:0] == mie_pkg::FN_SYSCALL &&
        gpr[mie_pkg::REG_V0] == mie_pkg::SYSCALL_EXIT)
      ins[5:0] = 6'h0D;
    return ins;
  endfunction

  task automatic run_random(int count, bit with_hold);
    word_in_t w;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req = 1;
      if ($urandom_range(11) == 0)
        w = '{mie_pkg::CMD_PRELOAD, $urandom, 10'($urandom), $urandom};
      else w = '{mie_pkg::CMD_EXEC, rand_instr(), 10'($urandom), $urandom};
      send_word(w);
    end
  endtask

  // Result side stall: random pattern plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_cnt <= LONG_HOLD;
      hold_taken <= 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      failed = 1;
      $display("%0t: %s expected %h actual %h", $time, name, exp, act);
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    word_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected result word, expected none actual pc %h", $time, out_pc);
      end else begin
        e = pending_q.pop_front();
        check_field("pc", e.pc, out_pc);
        check_field("halted", e.halted, out_halted);
        check_field("reg_written", e.reg_written, out_reg_written);
        check_field("reg_index", e.reg_index, out_reg_index);
        check_field("reg_value", e.reg_value, out_reg_value);
        check_field("store_done", e.store_done, out_store_done);
        check_field("store_index", e.store_index, out_store_index);
        check_field("store_mask", e.store_mask, out_store_mask);
        check_field("store_value", e.store_value, out_store_value);
        check_field("hi_value", e.hi_value, out_hi_value);
        check_field("lo_value", e.lo_value, out_lo_value);
        check_field("bad_instr", e.bad_instr, out_bad_instr);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    row_t table_rows [$];
    word_out_t z;
    z = '{default: 0};
    z.pc = mie_pkg::PC_RESET;
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = '0; in_valid = 1'b0;
    in_cmd = mie_pkg::CMD_EXEC;
    in_instr = '0; in_load_index = '0; in_load_word = '0; out_stall = 1'b0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < mie_pkg::DMEM_WORDS; i++) begin dmem[i] = '0; dmem_ok[i] = '0; end
    hi_q = '0; lo_q = '0; pc_q = mie_pkg::PC_RESET; start_pc_q = mie_pkg::PC_RESET;
    halt_q = 0;

    // Directed rows: preloads at the index extremes, unknown opcode, then each group
    table_rows.push_back('{'{mie_pkg::CMD_PRELOAD, 32'h0, 10'd0, 32'h0}, 1, z});
    table_rows.push_back('{'{mie_pkg::CMD_PRELOAD, 32'hFFFFFFFF, 10'h3FF, 32'hFFFFFFFF},
                          1, z});
    z.pc = mie_pkg::PC_RESET + 4; z.bad_instr = 1;
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'hFC000000, 10'd0, 32'h0}, 1, z});
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h3C01FFFF, 10'd0, 32'h0}, 0, z}); // lui
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h3402FFFF, 10'd0, 32'h0}, 0, z}); // ori
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h2403FFFF, 10'd0, 32'h0}, 0, z}); // -1
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h0020001A, 10'd0, 32'h0}, 0, z}); // / 0
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h3C048000, 10'd0, 32'h0}, 0, z});
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h0083001A, 10'd0, 32'h0}, 0, z}); // min/-1
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h00630018, 10'd0, 32'h0}, 0, z}); // mult
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h00630019, 10'd0, 32'h0}, 0, z}); // multu
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h0023001B, 10'd0, 32'h0}, 0, z}); // divu
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h00630021, 10'd0, 32'h0}, 0, z}); // to r0
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h24050100, 10'd0, 32'h0}, 0, z});
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h00A02809, 10'd0, 32'h0}, 0, z}); // jalr
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'hA4020002, 10'd0, 32'h0}, 0, z}); // sh
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h84070002, 10'd0, 32'h0}, 0, z}); // lh
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h80060003, 10'd0, 32'h0}, 0, z}); // lb
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h8C080003, 10'd0, 32'h0}, 0, z}); // lw
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h04700002, 10'd0, 32'h0}, 0, z}); // bltzal
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h04620000, 10'd0, 32'h0}, 0, z}); // bad sel
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h0000000C, 10'd0, 32'h0}, 0, z}); // syscall
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h0BFFFFFF, 10'd0, 32'h0}, 0, z}); // j
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h0C000000, 10'd0, 32'h0}, 0, z}); // jal
    table_rows.push_back('{'{mie_pkg::CMD_EXEC, 32'h1000FFFF, 10'd0, 32'h0}, 0, z}); // beq

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);
    write_start_pc(32'h0);

    foreach (table_rows[i])
      send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].res);
    drain_all();
    write_start_pc(32'hFFFFFFFF);

    stall_pct = 0;
    run_random(200, 0);
    stall_pct = 25;
    run_random(450, 0);
    drain_all();
    write_start_pc($urandom);

    stall_pct = 60;
    run_random(650, 1);
    drain_all();
    write_start_pc(mie_pkg::PC_RESET);

    // Exit call, then words that the halted core must ignore or still preload
    stall_pct = 20;
    send_word('{mie_pkg::CMD_EXEC, 32'h2402000A, 10'd0, 32'h0});
    send_word('{mie_pkg::CMD_EXEC, {mie_pkg::OP_SPECIAL, 20'h0, mie_pkg::FN_SYSCALL},
                10'd0, 32'h0});
    for (int i = 0; i < 12; i++)
      send_word('{($urandom_range(2) == 0), rand_instr(), 10'($urandom), $urandom});
    drain_all();

    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
sv/mie_pkg.sv
sv/mie_muldiv.sv
sv/mie_dpath.sv
sv/mie_ctrl.sv
sv/mips32_instruction_executor.sv
bench/tb_mips32_instruction_executor.sv
